/* hdl/exact_ratio_scale_accumulator_defines.svh */
// Assertion macros for the exact-ratio scale accumulator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef EXACT_RATIO_SCALE_ACCUMULATOR_DEFINES_SVH
`define EXACT_RATIO_SCALE_ACCUMULATOR_DEFINES_SVH
`ifndef SYNTH
// Check a property on every rising edge, skipped while reset is high.
`define ERSA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ersa assertion failed");
// Check a property on every rising edge, reset included.
`define ERSA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ersa assertion failed");
`else
`define ERSA_ASSERT(label, clk, rst, prop)
`define ERSA_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* hdl/ersa_pkg.sv */
// Shared types and constants for the exact-ratio scale accumulator.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package ersa_pkg;

  localparam int AMOUNT_W = 16;
  localparam int RATIO_W  = 32;
  localparam int TOTAL_W  = 16;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 5;

  // Last step index of the multiply and divide phases.
  localparam logic [CNT_W-1:0] MUL_LAST = 5'd15;
  localparam logic [CNT_W-1:0] DIV_LAST = 5'd31;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_INEXACT   = 2'd2,
    ST_BAD_RATIO = 2'd3
  } status_t;

endpackage

`default_nettype wire

/* hdl/ersa_channels.sv */
// Valid/ready channel interfaces for the item and result streams.
// Depends on ersa_pkg for field widths.
`default_nettype none

interface ersa_item_if
  import ersa_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [AMOUNT_W-1:0] amount_low;
  logic                amount_high_nonzero;
  logic [RATIO_W-1:0]  ratio_numerator;
  logic [RATIO_W-1:0]  ratio_denominator;
  logic                restart;

  modport source (
    output valid, amount_low, amount_high_nonzero, ratio_numerator,
           ratio_denominator, restart,
    input  ready
  );
  modport sink (
    input  valid, amount_low, amount_high_nonzero, ratio_numerator,
           ratio_denominator, restart,
    output ready
  );
endinterface

interface ersa_result_if
  import ersa_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TOTAL_W-1:0]  total;

  modport source (output valid, status, total, input ready);
  modport sink (input valid, status, total, output ready);
endinterface

`default_nettype wire

/* hdl/exact_ratio_scale_accumulator.sv */
// Exact-ratio scale accumulator: scales each amount by numerator/denominator
// and keeps a 16-bit running total. Depends on ersa_pkg, the channel
// interfaces and exact_ratio_scale_accumulator_defines.svh.
//
// One item is worked at a time. Where the status is decided up front (wide
// amount, zero ratio, equal ratio) the item goes straight to the final
// cycle; otherwise it first passes a bit-serial shift-add multiply (one
// amount bit per cycle, MSB first) and a restoring divide (one quotient bit
// per cycle), then the final cycle forms the sum. A product past 32 bits
// skips the divide. The item port opens on the cycle after the result is
// loaded, so a new item is taken only once the last one is through. The
// final cycle waits while the output register still holds an untaken
// result, which stalls the item port. The exactness test uses the divide
// remainder: since the product is formed exactly, floor(q*den/num) equals
// the amount exactly when the remainder is zero. On any error the running
// total is held; a restart clears it before the item is evaluated.
`default_nettype none
`include "exact_ratio_scale_accumulator_defines.svh"

module exact_ratio_scale_accumulator
  import ersa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  ersa_item_if.sink     item,
  ersa_result_if.source result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FINISH
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     cnt;
  logic [AMOUNT_W-1:0]  amt_sr;     // amount bits, MSB first into the multiply
  logic [RATIO_W-1:0]   num;
  logic [RATIO_W-1:0]   den;
  logic [RATIO_W-1:0]   quo;        // product, then dividend/quotient shifter
  logic [RATIO_W-1:0]   rem;
  logic                 prod_ovf;   // sticky: product passed 32 bits
  status_t              status_pre; // status decided before the sum
  logic [TOTAL_W-1:0]   total;
  logic                 res_valid;
  status_t              res_status;
  logic [TOTAL_W-1:0]   res_total;

  logic                 item_acc;
  logic [RATIO_W+1:0]   mul_next;
  logic [RATIO_W:0]     div_trial;
  logic                 div_ge;
  logic [RATIO_W-1:0]   rem_next;
  logic [TOTAL_W:0]     sum_wide;
  logic                 sum_ovf;
  status_t              fin_status;

  assign item.ready    = (state == S_IDLE);
  assign item_acc      = item.valid && item.ready;
  assign result.valid  = res_valid;
  assign result.status = res_status;
  assign result.total  = res_total;

  always_comb begin
    // Multiply step: double the partial product, add num when the amount bit is set.
    mul_next  = {1'b0, quo, 1'b0} + {2'b00, (amt_sr[AMOUNT_W-1] ? num : '0)};
    // Divide step: bring in the next dividend bit and try to subtract.
    div_trial = {rem, quo[RATIO_W-1]};
    div_ge    = (div_trial >= {1'b0, den});
    rem_next  = div_ge ? RATIO_W'(div_trial - {1'b0, den}) : div_trial[RATIO_W-1:0];
    // Final add of the scaled amount onto the running total.
    sum_wide  = {1'b0, total} + {1'b0, quo[TOTAL_W-1:0]};
    sum_ovf   = (quo[RATIO_W-1:TOTAL_W] != '0) || sum_wide[TOTAL_W];
    if (status_pre != ST_OK) begin
      fin_status = status_pre;
    end else if (sum_ovf) begin
      fin_status = ST_OVERFLOW;
    end else begin
      fin_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      total      <= '0;
      res_valid  <= 1'b0;
      prod_ovf   <= 1'b0;
      status_pre <= ST_OK;
    end else begin
      // Drop the result once the sink takes the transaction; the final cycle
      // loads the next one itself.
      if (result.ready && state != S_FINISH) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_acc) begin
            amt_sr   <= item.amount_low;
            num      <= item.ratio_numerator;
            den      <= item.ratio_denominator;
            rem      <= '0;
            cnt      <= '0;
            prod_ovf <= 1'b0;
            if (item.restart) begin
              total <= '0;
            end
            if (item.amount_high_nonzero) begin
              status_pre <= ST_OVERFLOW;
              state      <= S_FINISH;
            end else if (item.ratio_numerator == '0 || item.ratio_denominator == '0) begin
              status_pre <= ST_BAD_RATIO;
              state      <= S_FINISH;
            end else if (item.ratio_numerator == item.ratio_denominator) begin
              // Equal ratio: add the amount unscaled.
              status_pre <= ST_OK;
              quo        <= {{(RATIO_W-AMOUNT_W){1'b0}}, item.amount_low};
              state      <= S_FINISH;
            end else begin
              status_pre <= ST_OK;
              quo        <= '0;
              state      <= S_MUL;
            end
          end
        end
        S_MUL: begin
          quo    <= mul_next[RATIO_W-1:0];
          amt_sr <= {amt_sr[AMOUNT_W-2:0], 1'b0};
          if (mul_next[RATIO_W+1:RATIO_W] != 2'b00) begin
            prod_ovf <= 1'b1;
          end
          if (cnt == MUL_LAST) begin
            cnt <= '0;
            if (prod_ovf || mul_next[RATIO_W+1:RATIO_W] != 2'b00) begin
              status_pre <= ST_OVERFLOW;
              state      <= S_FINISH;
            end else begin
              state <= S_DIV;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DIV: begin
          rem <= rem_next;
          quo <= {quo[RATIO_W-2:0], div_ge};
          if (cnt == DIV_LAST) begin
            cnt   <= '0;
            state <= S_FINISH;
            if (rem_next != '0) begin
              status_pre <= ST_INEXACT;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FINISH: begin
          // Hold here until the output register is free.
          if (!res_valid || result.ready) begin
            res_valid  <= 1'b1;
            res_status <= fin_status;
            if (fin_status == ST_OK) begin
              total     <= sum_wide[TOTAL_W-1:0];
              res_total <= sum_wide[TOTAL_W-1:0];
            end else begin
              res_total <= total;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A wide amount goes straight to the final cycle as an overflow.
  `ERSA_ASSERT(a_wide_short_path, clk, rst, (item_acc && item.amount_high_nonzero) |=> (state == S_FINISH && status_pre == ST_OVERFLOW))
  // The running total moves only on an accepted item or at the final cycle.
  `ERSA_ASSERT(a_total_hold, clk, rst, (!item_acc && state != S_FINISH) |=> $stable(total))
  // The partial remainder always stays below the divisor.
  `ERSA_ASSERT(a_rem_bound, clk, rst, (state == S_DIV) |-> (rem < den))
  // The step counter never runs past the multiply length while multiplying.
  `ERSA_ASSERT(a_mul_count, clk, rst, (state == S_MUL) |-> (cnt <= MUL_LAST))

endmodule

`default_nettype wire
